// ----- rtl/core/shamir_two_of_three_gf256_codec_unit_macros.svh -----
// assertion macros used by the codec unit rtl file
`ifndef SHAMIR_TWO_OF_THREE_GF256_CODEC_UNIT_MACROS_SVH
`define SHAMIR_TWO_OF_THREE_GF256_CODEC_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled while reset is low
`define S23GF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication, disabled while reset is low
`define S23GF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define S23GF_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define S23GF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/s23gf_pkg.sv -----
`timescale 1ns / 1ps

package s23gf_pkg;

	// field reduction polynomial x^8+x^4+x^3+x+1
	localparam logic [8:0] GF_POLY = 9'h11B;

	// valid share coordinates
	localparam logic [7:0] COORD_MIN = 8'd1;
	localparam logic [7:0] COORD_MAX = 8'd3;

	// register reset values
	localparam logic [7:0] COORD_FIRST_RST  = 8'd1;
	localparam logic [7:0] COORD_SECOND_RST = 8'd2;

	// register indexes
	typedef enum logic {
		CFG_COORD_FIRST  = 1'b0,
		CFG_COORD_SECOND = 1'b1
	} cfg_idx_t;

	// operations
	typedef enum logic {
		OP_SPLIT = 1'b0,
		OP_RECON = 1'b1
	} op_t;

	// status codes
	typedef enum logic {
		STATUS_OK  = 1'b0,
		STATUS_ERR = 1'b1
	} status_t;

	// lagrange weights for the configured coordinate pair
	typedef struct packed {
		logic       bad;
		logic [7:0] wa;
		logic [7:0] wb;
	} coef_t;

	// multiply by x in the field
	function automatic logic [7:0] gf_xtime(input logic [7:0] a);
		logic [7:0] r;
		r = {a[6:0], 1'b0};
		if (a[7]) begin
			r = r ^ GF_POLY[7:0];
		end
		return r;
	endfunction

	// carry-free shift-and-add product
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] x;
		acc = 8'h00;
		x   = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				acc = acc ^ x;
			end
			x = gf_xtime(x);
		end
		return acc;
	endfunction

	// weights xb/(xa^xb) and xa/(xa^xb) for each legal pair
	function automatic coef_t lagrange_coef(input logic [7:0] xa, input logic [7:0] xb);
		coef_t c;
		c.bad = 1'b0;
		c.wa  = 8'h00;
		c.wb  = 8'h00;
		case ({xa, xb})
			{8'd1, 8'd2}: begin c.wa = 8'hF7; c.wb = 8'hF6; end
			{8'd2, 8'd1}: begin c.wa = 8'hF6; c.wb = 8'hF7; end
			{8'd1, 8'd3}: begin c.wa = 8'h8C; c.wb = 8'h8D; end
			{8'd3, 8'd1}: begin c.wa = 8'h8D; c.wb = 8'h8C; end
			{8'd2, 8'd3}: begin c.wa = 8'h03; c.wb = 8'h02; end
			{8'd3, 8'd2}: begin c.wa = 8'h02; c.wb = 8'h03; end
			default: begin
				// out of range or equal coordinates
				c.bad = 1'b1;
			end
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/core/shamir_two_of_three_gf256_codec_unit.sv -----
`timescale 1ns / 1ps
// 2-of-3 secret sharing codec over GF(2^8), one byte per item.
// input channel: in_valid/in_ready with opcode, data_first, data_second and
// random_coeff. opcode split turns a secret byte and a random byte into the
// three share bytes; opcode reconstruct combines two share bytes taken at the
// coordinates held in coord_first/coord_second into the secret byte.
// output channel: out_valid/out_ready with share_one..share_three, recovered
// and status; exactly one result item per input item, in order.
// configuration: cfg_wr_en writes cfg_data into register cfg_index
// (0 coord_first, 1 coord_second); write only while the block is empty.
// ordering: the accepting edge loads the input register, and the result register
// loads from it when it is empty or being read.
// throughput: one item per cycle while out_ready stays high, set by the single combinational
// field-arithmetic pass between the two registers.
// stalls: when out_ready is low a full result register holds, the input
// register still fills, and in_ready drops once both are full.
// reset: both stages empty, coord_first = 1, coord_second = 2.
`include "shamir_two_of_three_gf256_codec_unit_macros.svh"

module shamir_two_of_three_gf256_codec_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       opcode,
	input  logic [7:0] data_first,
	input  logic [7:0] data_second,
	input  logic [7:0] random_coeff,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] share_one,
	output logic [7:0] share_two,
	output logic [7:0] share_three,
	output logic [7:0] recovered,
	output logic       status,
	input  logic       cfg_wr_en,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	logic [7:0] coord_first_q;
	logic [7:0] coord_second_q;

	logic       v_s1;
	logic       op_s1;
	logic [7:0] d1_s1;
	logic [7:0] d2_s1;
	logic [7:0] cf_s1;

	logic       v_s2;
	logic [7:0] share_one_s2;
	logic [7:0] share_two_s2;
	logic [7:0] share_three_s2;
	logic [7:0] recovered_s2;
	logic       status_s2;

	logic       adv_s1;
	logic       adv_s2;

	s23gf_pkg::coef_t coef;
	logic [7:0] cf_x2;
	logic [7:0] n_one;
	logic [7:0] n_two;
	logic [7:0] n_three;
	logic [7:0] n_rec;
	logic       n_st;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_first_q  <= s23gf_pkg::COORD_FIRST_RST;
			coord_second_q <= s23gf_pkg::COORD_SECOND_RST;
		end else if (cfg_wr_en) begin
			case (s23gf_pkg::cfg_idx_t'(cfg_index))
				s23gf_pkg::CFG_COORD_FIRST:  coord_first_q  <= cfg_data;
				s23gf_pkg::CFG_COORD_SECOND: coord_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline flow control
	assign adv_s2   = v_s1 && (!v_s2 || out_ready);
	assign adv_s1   = in_valid && in_ready;
	assign in_ready = !v_s1 || adv_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			op_s1 <= opcode;
			d1_s1 <= data_first;
			d2_s1 <= data_second;
			cf_s1 <= random_coeff;
		end
	end

	// weights depend only on the coordinate registers
	assign coef  = s23gf_pkg::lagrange_coef(coord_first_q, coord_second_q);
	assign cf_x2 = s23gf_pkg::gf_xtime(cf_s1);

	// split or interpolate
	always_comb begin
		n_one   = 8'h00;
		n_two   = 8'h00;
		n_three = 8'h00;
		n_rec   = 8'h00;
		n_st    = s23gf_pkg::STATUS_OK;
		case (s23gf_pkg::op_t'(op_s1))
			s23gf_pkg::OP_SPLIT: begin
				n_one   = d1_s1 ^ cf_s1;
				n_two   = d1_s1 ^ cf_x2;
				n_three = d1_s1 ^ cf_x2 ^ cf_s1;
			end
			s23gf_pkg::OP_RECON: begin
				if (coef.bad) begin
					n_st = s23gf_pkg::STATUS_ERR;
				end else begin
					n_rec = s23gf_pkg::gf_mul(d1_s1, coef.wa)
						^ s23gf_pkg::gf_mul(d2_s1, coef.wb);
				end
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (!v_s2 || out_ready) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			share_one_s2   <= n_one;
			share_two_s2   <= n_two;
			share_three_s2 <= n_three;
			recovered_s2   <= n_rec;
			status_s2      <= n_st;
		end
	end

	assign out_valid   = v_s2;
	assign share_one   = share_one_s2;
	assign share_two   = share_two_s2;
	assign share_three = share_three_s2;
	assign recovered   = recovered_s2;
	assign status      = status_s2;

	// legal weights sum to one, so a constant polynomial reconstructs
	`S23GF_ASSERT_IMPLY(a_coef_sum, clk, arst_n, !coef.bad, (coef.wa ^ coef.wb) == 8'h01)

	// the three shares xor back to the secret
	`S23GF_ASSERT_NEXT(a_split_xor, clk, arst_n, adv_s2 && (op_s1 == s23gf_pkg::OP_SPLIT),
		(share_one ^ share_two ^ share_three) == $past(d1_s1))

	// split results carry no recovered byte and no error
	`S23GF_ASSERT_NEXT(a_split_clean, clk, arst_n, adv_s2 && (op_s1 == s23gf_pkg::OP_SPLIT),
		(recovered == 8'h00) && (status == s23gf_pkg::STATUS_OK))

	// an error result carries only zero bytes
	`S23GF_ASSERT_IMPLY(a_err_zero, clk, arst_n, v_s2 && (status == s23gf_pkg::STATUS_ERR),
		(recovered == 8'h00) && (share_one == 8'h00) && (share_two == 8'h00)
		&& (share_three == 8'h00))

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;

	localparam int unsigned CLK_HALF        = 10;
	localparam int unsigned RESET_CYCLES    = 12;
	localparam logic [8:0]  FIELD_POLY      = 9'h11B;
	localparam logic [7:0]  FIELD_ORDER     = 8'd255;
	localparam int unsigned LONG_HOLD       = 200;
	localparam int unsigned PRESSURE_ITEMS  = 30;
	localparam int unsigned RANDOM_PHASES   = 8;
	localparam int unsigned PHASE_ITEMS     = 95;
	localparam int unsigned FULL_RATE_ITEMS = 100;
	localparam int unsigned SETTLE_CYCLES   = 4;
	localparam int unsigned CYCLE_LIMIT     = 200000;

	// one expected result item
	typedef struct packed {
		logic [7:0]          s1;
		logic [7:0]          s2;
		logic [7:0]          s3;
		logic [7:0]          rec;
		s23gf_pkg::status_t  st;
	} share_result_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       opcode;
	logic [7:0] data_first;
	logic [7:0] data_second;
	logic [7:0] random_coeff;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] share_one;
	logic [7:0] share_two;
	logic [7:0] share_three;
	logic [7:0] recovered;
	logic       status;
	logic       cfg_wr_en;
	logic       cfg_index;
	logic [7:0] cfg_data;

	// local copy of the coordinate registers
	logic [7:0] coord_a;
	logic [7:0] coord_b;

	share_result_t pending_results[$];
	int unsigned   errors;
	int unsigned   cycles;
	int unsigned   n_split;
	int unsigned   n_recon;
	int unsigned   n_coord_err;
	int unsigned   n_cfg_writes;
	bit            tx_idle_en;
	bit            rx_idle_en;
	bit            hold_req;
	int unsigned   hold_left;
	int unsigned   gap_left;

	shamir_two_of_three_gf256_codec_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.data_first  (data_first),
		.data_second (data_second),
		.random_coeff(random_coeff),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.share_one   (share_one),
		.share_two   (share_two),
		.share_three (share_three),
		.recovered   (recovered),
		.status      (status),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// clock
	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: run limit reached with %0d items outstanding", $time,
				pending_results.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// field product, msb-first horner form
	function automatic logic [7:0] field_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int k = 7; k >= 0; k--) begin
			p = {p[6:0], 1'b0} ^ (p[7] ? FIELD_POLY[7:0] : 8'h00);
			if (a[k]) begin
				p = p ^ b;
			end
		end
		return p;
	endfunction

	// inverse as a^(order-1), square and multiply
	function automatic logic [7:0] field_inv(input logic [7:0] a);
		logic [7:0] acc;
		logic [7:0] sq;
		logic [7:0] e;
		acc = 8'h01;
		sq  = a;
		e   = FIELD_ORDER - 8'd1;
		while (e != 8'd0) begin
			if (e[0]) begin
				acc = field_mul(acc, sq);
			end
			sq = field_mul(sq, sq);
			e  = e >> 1;
		end
		return acc;
	endfunction

	function automatic logic coords_legal();
		return (coord_a >= s23gf_pkg::COORD_MIN) && (coord_a <= s23gf_pkg::COORD_MAX) &&
			(coord_b >= s23gf_pkg::COORD_MIN) && (coord_b <= s23gf_pkg::COORD_MAX) &&
			(coord_a != coord_b);
	endfunction

	// expected shares or recovered secret for one item
	function automatic share_result_t predict_shares(input s23gf_pkg::op_t op,
		input logic [7:0] d1, input logic [7:0] d2, input logic [7:0] rc);
		share_result_t r;
		logic [7:0]    den_inv;
		r = '0;
		r.st = s23gf_pkg::STATUS_OK;
		if (op == s23gf_pkg::OP_SPLIT) begin
			r.s1 = d1 ^ field_mul(rc, 8'd1);
			r.s2 = d1 ^ field_mul(rc, 8'd2);
			r.s3 = d1 ^ field_mul(rc, 8'd3);
		end else if (!coords_legal()) begin
			r.st = s23gf_pkg::STATUS_ERR;
		end else begin
			den_inv = field_inv(coord_a ^ coord_b);
			r.rec = field_mul(d1, field_mul(coord_b, den_inv)) ^
				field_mul(d2, field_mul(coord_a, den_inv));
		end
		return r;
	endfunction

	// append one expectation to the scoreboard
	task automatic expect_result(input share_result_t r);
		pending_results = {pending_results, r};
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	// result checker, sampled on the falling edge before the accepting edge
	always @(negedge clk) begin : result_check
		share_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result expected none actual %h %h %h %h %b", $time,
					share_one, share_two, share_three, recovered, status);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("share_one", want.s1, share_one);
				check_field("share_two", want.s2, share_two);
				check_field("share_three", want.s3, share_three);
				check_field("recovered", want.rec, recovered);
				check_field("status", {7'd0, want.st}, {7'd0, status});
			end
		end
	end

	// receiver: long hold on request, short random stalls otherwise
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (gap_left != 0) begin
			gap_left--;
			out_ready <= 1'b0;
		end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
			gap_left = $urandom_range(1, 5) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// offer one item and record its expectation once accepted
	task automatic send_item(input s23gf_pkg::op_t op, input logic [7:0] d1,
		input logic [7:0] d2, input logic [7:0] rc);
		int unsigned gap;
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		data_first   <= d1;
		data_second  <= d2;
		random_coeff <= rc;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		expect_result(predict_shares(op, d1, d2, rc));
		if (op == s23gf_pkg::OP_SPLIT) begin
			n_split++;
		end else begin
			n_recon++;
			if (!coords_legal()) begin
				n_coord_err++;
			end
		end
	endtask

	task automatic send_random_item();
		send_item(s23gf_pkg::op_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	// stop offering and wait until every result is back
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// drive one register write; the caller drops the write enable
	task automatic cfg_write(input s23gf_pkg::cfg_idx_t idx, input logic [7:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		if (idx == s23gf_pkg::CFG_COORD_FIRST) begin
			coord_a = value;
		end else begin
			coord_b = value;
		end
		n_cfg_writes++;
	endtask

	task automatic set_coords(input logic [7:0] xa, input logic [7:0] xb);
		wait_idle();
		cfg_write(s23gf_pkg::CFG_COORD_FIRST, xa);
		cfg_write(s23gf_pkg::CFG_COORD_SECOND, xb);
		cfg_wr_en <= 1'b0;
	endtask

	// split extremes, zero coefficient and alternating bit patterns
	task automatic test_split_directed();
		send_item(s23gf_pkg::OP_SPLIT, 8'h00, 8'h00, 8'h00);
		send_item(s23gf_pkg::OP_SPLIT, 8'hFF, 8'hFF, 8'h00);
		send_item(s23gf_pkg::OP_SPLIT, 8'h00, 8'hAA, 8'hFF);
		send_item(s23gf_pkg::OP_SPLIT, 8'hFF, 8'h55, 8'hFF);
		send_item(s23gf_pkg::OP_SPLIT, 8'h55, 8'h00, 8'h80);
		send_item(s23gf_pkg::OP_SPLIT, 8'hAA, 8'hFF, 8'h01);
	endtask

	// reconstruction at reset coordinates and at every legal pair
	task automatic test_recon_pairs();
		logic [7:0] pairs[6][2];
		pairs = '{'{8'd1, 8'd3}, '{8'd3, 8'd1}, '{8'd2, 8'd3},
			'{8'd3, 8'd2}, '{8'd2, 8'd1}, '{8'd1, 8'd2}};
		send_item(s23gf_pkg::OP_RECON, 8'h00, 8'hFF, 8'h55);
		send_item(s23gf_pkg::OP_RECON, 8'hFF, 8'h00, 8'hAA);
		foreach (pairs[i]) begin
			set_coords(pairs[i][0], pairs[i][1]);
			send_item(s23gf_pkg::OP_RECON, 8'hFF, 8'hFF, 8'h00);
			send_random_item();
		end
	endtask

	// coordinates out of range or equal
	task automatic test_bad_coords();
		set_coords(8'd0, 8'd1);
		send_item(s23gf_pkg::OP_RECON, 8'h12, 8'h34, 8'h00);
		set_coords(8'd3, 8'd4);
		send_item(s23gf_pkg::OP_RECON, 8'hFF, 8'hFF, 8'hFF);
		set_coords(8'd2, 8'd2);
		send_item(s23gf_pkg::OP_RECON, 8'hA5, 8'h5A, 8'h00);
		set_coords(8'hFF, 8'hFF);
		send_item(s23gf_pkg::OP_RECON, 8'h01, 8'h02, 8'h03);
		send_item(s23gf_pkg::OP_SPLIT, 8'h3C, 8'h00, 8'hC3);
		set_coords(8'd1, 8'hFF);
		send_item(s23gf_pkg::OP_RECON, 8'h77, 8'h88, 8'h99);
	endtask

	// receiver holds off while the sender keeps offering items, then all results drain
	task automatic test_backpressure();
		set_coords(8'd1, 8'd2);
		tx_idle_en = 1'b0;
		hold_req   = 1'b1;
		repeat (PRESSURE_ITEMS) send_random_item();
		tx_idle_en = 1'b1;
		wait_idle();
	endtask

	// random items over several coordinate settings
	task automatic test_random_phases();
		logic [7:0] xa;
		logic [7:0] xb;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if ($urandom_range(0, 3) != 0) begin
				xa = 8'($urandom_range(1, 3));
				xb = 8'(((xa + $urandom_range(0, 1)) % 3) + 1);
			end else begin
				xa = 8'($urandom_range(0, 255));
				xb = 8'($urandom_range(0, 255));
			end
			set_coords(xa, xb);
			repeat (PHASE_ITEMS) send_random_item();
		end
	endtask

	// back-to-back items with no stalls on either side
	task automatic test_full_rate();
		set_coords(8'd3, 8'd1);
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		repeat (FULL_RATE_ITEMS) send_random_item();
		wait_idle();
	endtask

	initial begin
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		opcode       <= s23gf_pkg::OP_SPLIT;
		data_first   <= 8'h00;
		data_second  <= 8'h00;
		random_coeff <= 8'h00;
		out_ready    <= 1'b0;
		cfg_wr_en    <= 1'b0;
		cfg_index    <= s23gf_pkg::CFG_COORD_FIRST;
		cfg_data     <= 8'h00;
		tx_idle_en   = 1'b1;
		rx_idle_en   = 1'b1;
		hold_req     = 1'b0;
		coord_a      = s23gf_pkg::COORD_FIRST_RST;
		coord_b      = s23gf_pkg::COORD_SECOND_RST;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_split_directed();
		test_recon_pairs();
		test_bad_coords();
		test_backpressure();
		test_random_phases();
		test_full_rate();

		if (pending_results.size() != 0) begin
			$display("%0t: leftover results expected 0 actual %0d", $time,
				pending_results.size());
			errors++;
		end
		$display("split %0d bytes, reconstructed %0d (%0d with bad coordinates)",
			n_split, n_recon, n_coord_err);
		$display("%0d register writes, long output hold and full-rate stretch included",
			n_cfg_writes);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/s23gf_pkg.sv
rtl/core/shamir_two_of_three_gf256_codec_unit.sv
test/tb.sv
